// ===== src/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned BlockWords = 16;

  typedef enum logic [1:0] {
    OP_WORD  = 2'd0,
    OP_PAD   = 2'd1,
    OP_LAST  = 2'd2
  } op_e;

  // request from the front to the back: one 32-bit schedule word plus its role
  typedef struct packed {
    op_e         op;
    logic [31:0] word;
  } req_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    FS_COLLECT,
    FS_PAD,
    FS_LEN_HI,
    FS_LEN_LO
  } front_state_e;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha256_message_hasher_top.sv =====
// SHA-256 over a byte stream: push one item per cycle while full is low (optional byte,
// optional end flag). The front packs bytes into 32-bit schedule words and generates
// padding; a small request queue feeds the compression core, which loads 16 words and
// then runs 64 rounds at one per cycle. Byte intake stalls while the queue is full or
// padding is sent. After the end flag (plus padding, up to two blocks) eight digest words
// are presented most significant first; the next message may start at once.
module sha256_message_hasher_top #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        final_word_o
);

  sha256_pkg::req_t f_req, q_req;
  logic f_valid, q_ready, q_valid, q_pop;

  sha256_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .data_byte_i, .byte_present_i, .end_of_message_i,
    .req_valid_o(f_valid), .req_ready_i(q_ready), .req_o(f_req)
  );

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_i(f_valid), .wr_data_i(f_req), .ready_o(q_ready),
    .valid_o(q_valid), .rd_i(q_pop), .rd_data_o(q_req)
  );

  sha256_core u_core (
    .clk_i, .rst_ni, .req_valid_i(q_valid), .req_pop_o(q_pop), .req_i(q_req),
    .empty_o(empty), .pop_i(pop), .digest_word_o, .word_number_o, .final_word_o
  );

  a_final_is_seven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (final_word_o == (word_number_o == 3'd7)))
    else $error("final flag mismatch");

  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !q_ready |=> f_valid && $stable(f_req))
    else $error("request lost");

endmodule

// ===== src/sha256_front.sv =====
module sha256_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_present_i,
  input  logic              end_of_message_i,
  output logic              req_valid_o,
  input  logic              req_ready_i,
  output sha256_pkg::req_t  req_o
);

  sha256_pkg::front_state_e state_q, state_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  bpos_q, bpos_d;
  logic [3:0]  wcnt_q, wcnt_d;
  logic [60:0] total_q, total_d;
  logic        pad_byte_q, pad_byte_d;
  logic [63:0] bits;
  logic        accept;
  logic [31:0] merged;
  logic        word_done;

  assign bits = {total_q, 3'b000};
  assign full_o = (state_q != sha256_pkg::FS_COLLECT) || !req_ready_i;
  assign accept = push_i && !full_o;

  always_comb begin
    merged = acc_q;
    merged[8'(31 - 8 * bpos_q) -: 8] = data_byte_i;
  end

  always_comb begin
    state_d = state_q;
    acc_d = acc_q;
    bpos_d = bpos_q;
    wcnt_d = wcnt_q;
    total_d = total_q;
    pad_byte_d = pad_byte_q;
    req_valid_o = 1'b0;
    req_o.op = sha256_pkg::OP_WORD;
    req_o.word = merged;
    word_done = 1'b0;
    case (state_q)
      sha256_pkg::FS_COLLECT: begin
        if (accept && byte_present_i) begin
          total_d = total_q + 61'd1;
          acc_d = merged;
          bpos_d = bpos_q + 2'd1;
          if (bpos_q == 2'd3) begin
            req_valid_o = 1'b1;
            word_done = 1'b1;
          end
        end
        if (accept && end_of_message_i) begin
          state_d = sha256_pkg::FS_PAD;
          pad_byte_d = 1'b1;
        end
      end
      sha256_pkg::FS_PAD: begin
        // fill current word with 0x80 then zeros; stop at word 14
        req_o.word = acc_q;
        if (pad_byte_q) req_o.word[8'(31 - 8 * bpos_q) -: 8] = 8'h80;
        for (int i = 0; i < 4; i++) begin
          if (2'(i) > bpos_q || (!pad_byte_q && 2'(i) >= bpos_q)) begin
            req_o.word[31 - 8 * i -: 8] = 8'h00;
          end
        end
        if (!pad_byte_q && bpos_q == 2'd0) req_o.word = '0;
        req_o.op = sha256_pkg::OP_PAD;
        if (wcnt_q == 4'd14) begin
          req_valid_o = 1'b0;
          if (req_ready_i) state_d = sha256_pkg::FS_LEN_HI;
        end else begin
          req_valid_o = 1'b1;
          if (req_ready_i) begin
            word_done = 1'b1;
            pad_byte_d = 1'b0;
            bpos_d = 2'd0;
            acc_d = '0;
          end
        end
      end
      sha256_pkg::FS_LEN_HI: begin
        req_valid_o = 1'b1;
        req_o.word = bits[63:32];
        if (req_ready_i) begin
          word_done = 1'b1;
          state_d = sha256_pkg::FS_LEN_LO;
        end
      end
      sha256_pkg::FS_LEN_LO: begin
        req_valid_o = 1'b1;
        req_o.op = sha256_pkg::OP_LAST;
        req_o.word = bits[31:0];
        if (req_ready_i) begin
          word_done = 1'b1;
          state_d = sha256_pkg::FS_COLLECT;
          total_d = '0;
          bpos_d = 2'd0;
        end
      end
      default: state_d = sha256_pkg::FS_COLLECT;
    endcase
    if (word_done) wcnt_d = wcnt_q + 4'd1;
    if (state_q == sha256_pkg::FS_PAD && wcnt_q == 4'd14 && pad_byte_q) begin
      // 0x80 did not fit before the length: finish this block with zeros
      req_valid_o = req_ready_i;
      state_d = sha256_pkg::FS_PAD;
      if (req_ready_i) begin
        wcnt_d = wcnt_q + 4'd1;
        pad_byte_d = 1'b0;
        bpos_d = 2'd0;
        acc_d = '0;
      end
    end
  end

  // pad_byte at word 14 only when 0x80 lands at word 14: emit it, keep padding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::FS_COLLECT;
      bpos_q <= '0;
      wcnt_q <= '0;
      total_q <= '0;
      pad_byte_q <= 1'b0;
    end else begin
      state_q <= state_d;
      bpos_q <= bpos_d;
      wcnt_q <= wcnt_d;
      total_q <= total_d;
      pad_byte_q <= pad_byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ===== src/sha256_queue.sv =====
module sha256_queue #(
  parameter int unsigned Depth = sha256_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  sha256_pkg::req_t wr_data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             rd_i,
  output sha256_pkg::req_t rd_data_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha256_pkg::req_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;

  assign ready_o = cnt_q != (Aw+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && ready_o) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && ready_o) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i && valid_o) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr_i && ready_o) - (Aw+1)'(rd_i && valid_o);
    end
  end

endmodule

// ===== src/sha256_core.sv =====
module sha256_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_pop_o,
  input  sha256_pkg::req_t req_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_number_o,
  output logic             final_word_o
);

  sha256_pkg::back_state_e state_q, state_d;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  rnd_q;
  logic [3:0]  ld_q;
  logic        last_q;
  logic [2:0]  oi_q;
  logic [31:0] wt, s0, s1, t1, t2, bs0, bs1, ch, mj;
  logic        take;

  assign take = req_valid_i && state_q == sha256_pkg::ST_LOAD;
  assign req_pop_o = take;

  always_comb begin
    s0 = sha256_pkg::ror(w_q[1], 7) ^ sha256_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = sha256_pkg::ror(w_q[14], 17) ^ sha256_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
    wt = w_q[0];
    bs1 = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
        ^ sha256_pkg::ror(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + bs1 + ch + sha256_pkg::RoundK[rnd_q] + wt;
    bs0 = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
        ^ sha256_pkg::ror(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = bs0 + mj;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::ST_LOAD:  if (take && ld_q == 4'd15) state_d = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha256_pkg::ST_ADD;
      sha256_pkg::ST_ADD:   state_d = last_q ? sha256_pkg::ST_EMIT : sha256_pkg::ST_LOAD;
      sha256_pkg::ST_EMIT:  if (pop_i && oi_q == 3'd7) state_d = sha256_pkg::ST_LOAD;
      default:              state_d = sha256_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    empty_o = state_q != sha256_pkg::ST_EMIT;
    digest_word_o = h_q[oi_q];
    word_number_o = oi_q;
    final_word_o = oi_q == 3'd7;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_LOAD;
      rnd_q <= '0;
      ld_q <= '0;
      last_q <= 1'b0;
      oi_q <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
    end else begin
      state_q <= state_d;
      if (take) begin
        ld_q <= ld_q + 4'd1;
        if (ld_q == 4'd15) last_q <= req_i.op == sha256_pkg::OP_LAST;
      end
      if (state_q == sha256_pkg::ST_ROUND) rnd_q <= rnd_q + 6'd1;
      if (state_q == sha256_pkg::ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (state_q == sha256_pkg::ST_EMIT && pop_i) begin
        oi_q <= oi_q + 3'd1;
        if (oi_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= req_i.word;
      if (ld_q == 4'd15) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end
    if (state_q == sha256_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_q[0] + s0 + w_q[9] + s1;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule
